// ===== rtl/core/bpt_pkg.sv =====
// shared types, constants and the microprogram of the compensation block
package bpt_pkg;

   typedef enum logic [1:0] {
      FOP_CVT = 2'd0,
      FOP_ADD = 2'd1,
      FOP_SUB = 2'd2,
      FOP_MUL = 2'd3
   } fop_type;

   typedef logic [4:0] raddr_type;

   typedef struct packed {
      fop_type   op;
      raddr_type dst;
      raddr_type srca;
      raddr_type srcb;
   } instr_type;

   typedef struct packed {
      logic      load_in;
      logic      issue;
      logic      load_out;
      instr_type instr;
   } ctl_cmd_type;

   typedef struct packed {
      logic op_done;
      logic out_free;
   } ctl_sts_type;

   // configuration register indexes
   localparam logic [1:0] CSR_TEMP    = 2'd0;
   localparam logic [1:0] CSR_PRESS_A = 2'd1;
   localparam logic [1:0] CSR_PRESS_B = 2'd2;
   localparam logic [1:0] CSR_PRESS_C = 2'd3;

   localparam int CsrWidth = 48;

   // register file map; the first sixteen are also the conversion source codes
   localparam raddr_type R_T1  = 5'd0;
   localparam raddr_type R_T2  = 5'd1;
   localparam raddr_type R_T3  = 5'd2;
   localparam raddr_type R_P1  = 5'd3;
   localparam raddr_type R_P2  = 5'd4;
   localparam raddr_type R_P3  = 5'd5;
   localparam raddr_type R_P4  = 5'd6;
   localparam raddr_type R_P5  = 5'd7;
   localparam raddr_type R_P6  = 5'd8;
   localparam raddr_type R_P7  = 5'd9;
   localparam raddr_type R_P8  = 5'd10;
   localparam raddr_type R_P9  = 5'd11;
   localparam raddr_type R_P10 = 5'd12;
   localparam raddr_type R_P11 = 5'd13;
   localparam raddr_type R_UP  = 5'd14;
   localparam raddr_type R_UT  = 5'd15;
   localparam raddr_type R_D   = 5'd16;
   localparam raddr_type R_A   = 5'd17;
   localparam raddr_type R_B   = 5'd18;
   localparam raddr_type R_TL  = 5'd19;
   localparam raddr_type R_TL2 = 5'd20;
   localparam raddr_type R_TL3 = 5'd21;
   localparam raddr_type R_C   = 5'd22;
   localparam raddr_type R_O1  = 5'd23;
   localparam raddr_type R_S   = 5'd24;
   localparam raddr_type R_UP2 = 5'd25;
   localparam raddr_type R_E   = 5'd26;
   localparam raddr_type R_F   = 5'd27;

   localparam int NumCvt  = 16;
   localparam int ProgLen = 45;
   localparam logic [5:0] PcLast = 6'(ProgLen - 1);

   function automatic instr_type mk(input fop_type o, input raddr_type d,
                                    input raddr_type a, input raddr_type b);
      instr_type r;
      r.op   = o;
      r.dst  = d;
      r.srca = a;
      r.srcb = b;
      return r;
   endfunction

   // power-of-two scale applied to each converted integer
   function automatic logic signed [11:0] cvt_scale(input raddr_type idx);
      logic signed [11:0] s;
      case (idx)
         R_T1:    s = 12'sd8;
         R_T2:    s = -12'sd30;
         R_T3:    s = -12'sd48;
         R_P1:    s = -12'sd20;
         R_P2:    s = -12'sd29;
         R_P3:    s = -12'sd32;
         R_P4:    s = -12'sd37;
         R_P5:    s = 12'sd3;
         R_P6:    s = -12'sd6;
         R_P7:    s = -12'sd8;
         R_P8:    s = -12'sd15;
         R_P9:    s = -12'sd48;
         R_P10:   s = -12'sd48;
         R_P11:   s = -12'sd65;
         default: s = 12'sd0;
      endcase
      return s;
   endfunction

   function automatic instr_type prog(input logic [5:0] pc);
      instr_type r;
      if (pc < 6'(NumCvt)) begin
         r = mk(FOP_CVT, pc[4:0], pc[4:0], R_T1);
      end else begin
         case (pc)
            6'd16:   r = mk(FOP_SUB, R_D,   R_UT,  R_T1);
            6'd17:   r = mk(FOP_MUL, R_A,   R_D,   R_T2);
            6'd18:   r = mk(FOP_MUL, R_B,   R_D,   R_D);
            6'd19:   r = mk(FOP_MUL, R_B,   R_B,   R_T3);
            6'd20:   r = mk(FOP_ADD, R_TL,  R_A,   R_B);
            6'd21:   r = mk(FOP_MUL, R_TL2, R_TL,  R_TL);
            6'd22:   r = mk(FOP_MUL, R_TL3, R_TL2, R_TL);
            6'd23:   r = mk(FOP_MUL, R_A,   R_P6,  R_TL);
            6'd24:   r = mk(FOP_MUL, R_B,   R_P7,  R_TL2);
            6'd25:   r = mk(FOP_MUL, R_C,   R_P8,  R_TL3);
            6'd26:   r = mk(FOP_ADD, R_O1,  R_P5,  R_A);
            6'd27:   r = mk(FOP_ADD, R_O1,  R_O1,  R_B);
            6'd28:   r = mk(FOP_ADD, R_O1,  R_O1,  R_C);
            6'd29:   r = mk(FOP_MUL, R_A,   R_P2,  R_TL);
            6'd30:   r = mk(FOP_MUL, R_B,   R_P3,  R_TL2);
            6'd31:   r = mk(FOP_MUL, R_C,   R_P4,  R_TL3);
            6'd32:   r = mk(FOP_ADD, R_S,   R_P1,  R_A);
            6'd33:   r = mk(FOP_ADD, R_S,   R_S,   R_B);
            6'd34:   r = mk(FOP_ADD, R_S,   R_S,   R_C);
            6'd35:   r = mk(FOP_MUL, R_S,   R_UP,  R_S);
            6'd36:   r = mk(FOP_MUL, R_UP2, R_UP,  R_UP);
            6'd37:   r = mk(FOP_MUL, R_E,   R_P10, R_TL);
            6'd38:   r = mk(FOP_ADD, R_E,   R_P9,  R_E);
            6'd39:   r = mk(FOP_MUL, R_E,   R_UP2, R_E);
            6'd40:   r = mk(FOP_MUL, R_F,   R_UP2, R_UP);
            6'd41:   r = mk(FOP_MUL, R_F,   R_F,   R_P11);
            6'd42:   r = mk(FOP_ADD, R_E,   R_E,   R_F);
            6'd43:   r = mk(FOP_ADD, R_F,   R_O1,  R_S);
            6'd44:   r = mk(FOP_ADD, R_F,   R_F,   R_E);
            default: r = mk(FOP_ADD, R_F,   R_F,   R_E);
         endcase
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/bpt_req_if.sv =====
// sample channel: valid, ready and the raw pressure and temperature word
interface bpt_req_if;
   logic        valid;
   logic        ready;
   logic [23:0] raw_pressure;
   logic [23:0] raw_temperature;

   modport source (output valid, output raw_pressure, output raw_temperature, input ready);
   modport sink (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

// ===== rtl/core/bpt_rsp_if.sv =====
// result channel: valid, ready and the compensated reading word
interface bpt_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] temperature_bits;
   logic [31:0] pressure_bits;
   logic        reading_toggle;

   modport source (output valid, output temperature_bits, output pressure_bits,
                   output reading_toggle, input ready);
   modport sink (input valid, input temperature_bits, input pressure_bits,
                 input reading_toggle, output ready);
endinterface

// ===== rtl/core/bpt_fpu.sv =====
// binary32 add, subtract, multiply and integer convert, round to nearest even
module bpt_fpu (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  bpt_pkg::fop_type   op,
   input  logic [31:0]        opa,
   input  logic [31:0]        opb,
   input  logic [23:0]        cvt_mag,
   input  logic               cvt_neg,
   input  logic signed [11:0] cvt_scale,
   output logic               done,
   output logic [31:0]        result
);

   // operand unpack
   logic [7:0]  ea, eb, eua, eub;
   logic [23:0] ma, mb;
   logic [47:0] prod;
   logic signed [11:0] mq;

   // add path
   logic        sbe, swap, sx, sy, eff_sub, aneg;
   logic [23:0] mx, my;
   logic [7:0]  ex, ey, dexp;
   logic [4:0]  dc;
   logic [26:0] bx, by0, bysh, by;
   logic        astk;
   logic [27:0] sum28, amag;
   logic signed [11:0] aq;

   logic [47:0]        ex_w;
   logic signed [11:0] ex_q;
   logic               ex_s, ex_zs;

   logic               s1_v_ff;
   logic [47:0]        s1_w_ff;
   logic signed [11:0] s1_q_ff;
   logic               s1_s_ff;

   logic [5:0]         lead;
   logic               n1_v_ff, n1_s_ff, n1_zero_ff;
   logic [47:0]        n1_w_ff;
   logic signed [11:0] n1_q_ff;
   logic [5:0]         n1_l_ff;

   logic signed [11:0] be, ef, kk;
   logic [6:0]         kc, sh;
   logic [79:0]        x80, y80;
   logic               n2_v_ff, n2_s_ff, n2_zero_ff, n2_ovf_ff, n2_g_ff, n2_st_ff;
   logic [23:0]        n2_mant_ff;
   logic [7:0]         n2_e_ff;

   logic [30:0]        pack, rnd;
   logic               inc;
   logic               done_ff;
   logic [31:0]        res_ff;

   always_comb begin
      ea   = opa[30:23];
      eb   = opb[30:23];
      eua  = (ea == 8'd0) ? 8'd1 : ea;
      eub  = (eb == 8'd0) ? 8'd1 : eb;
      ma   = {(ea != 8'd0), opa[22:0]};
      mb   = {(eb != 8'd0), opb[22:0]};
      prod = 48'(ma) * 48'(mb);
      mq   = $signed({4'b0, eua}) + $signed({4'b0, eub}) - 12'sd300;

      sbe     = opb[31] ^ (op == bpt_pkg::FOP_SUB);
      swap    = eub > eua;
      mx      = swap ? mb : ma;
      my      = swap ? ma : mb;
      ex      = swap ? eub : eua;
      ey      = swap ? eua : eub;
      sx      = swap ? sbe : opa[31];
      sy      = swap ? opa[31] : sbe;
      eff_sub = sx ^ sy;
      dexp    = ex - ey;
      dc      = (dexp > 8'd27) ? 5'd27 : dexp[4:0];
      bx      = {mx, 3'b000};
      by0     = {my, 3'b000};
      bysh    = by0 >> dc;
      astk    = |(by0 & ~({27{1'b1}} << dc));
      by      = {bysh[26:1], bysh[0] | astk};
      sum28   = eff_sub ? ({1'b0, bx} - {1'b0, by}) : ({1'b0, bx} + {1'b0, by});
      aneg    = eff_sub & sum28[27];
      amag    = aneg ? (28'd0 - sum28) : sum28;
      aq      = $signed({4'b0, ex}) - 12'sd153;

      case (op)
         bpt_pkg::FOP_MUL: begin
            ex_w  = prod;
            ex_q  = mq;
            ex_s  = opa[31] ^ opb[31];
            ex_zs = opa[31] ^ opb[31];
         end
         bpt_pkg::FOP_ADD, bpt_pkg::FOP_SUB: begin
            ex_w  = {20'd0, amag};
            ex_q  = aq;
            ex_s  = aneg ? sy : sx;
            // exact cancellation gives +0, like signs keep theirs
            ex_zs = eff_sub ? 1'b0 : sx;
         end
         default: begin
            ex_w  = {24'd0, cvt_mag};
            ex_q  = cvt_scale;
            ex_s  = cvt_neg;
            ex_zs = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      s1_w_ff <= ex_w;
      s1_q_ff <= ex_q;
      s1_s_ff <= (ex_w == 48'd0) ? ex_zs : ex_s;
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= start;
      end
   end

   // leading one position
   always_comb begin
      lead = 6'd0;
      for (int i = 0; i < 48; i++) begin
         if (s1_w_ff[i]) lead = 6'(i);
      end
   end

   always_ff @(posedge clock) begin
      n1_w_ff    <= s1_w_ff;
      n1_q_ff    <= s1_q_ff;
      n1_s_ff    <= s1_s_ff;
      n1_l_ff    <= lead;
      n1_zero_ff <= (s1_w_ff == 48'd0);
      if (reset) begin
         n1_v_ff <= 1'b0;
      end else begin
         n1_v_ff <= s1_v_ff;
      end
   end

   // pick the result lsb position, subnormals pin the exponent at one
   always_comb begin
      be  = n1_q_ff + $signed({6'd0, n1_l_ff}) + 12'sd127;
      ef  = (be < 12'sd1) ? 12'sd1 : be;
      kk  = ef - n1_q_ff - 12'sd124;
      kc  = (kk > 12'sd79) ? 7'd79 : kk[6:0];
      sh  = kc - 7'd1;
      x80 = {6'd0, n1_w_ff, 26'd0};
      y80 = x80 >> sh;
   end

   always_ff @(posedge clock) begin
      n2_mant_ff <= y80[24:1];
      n2_g_ff    <= y80[0];
      n2_st_ff   <= |(x80 & ~({80{1'b1}} << sh));
      n2_e_ff    <= ef[7:0];
      n2_ovf_ff  <= (ef > 12'sd254);
      n2_s_ff    <= n1_s_ff;
      n2_zero_ff <= n1_zero_ff;
      if (reset) begin
         n2_v_ff <= 1'b0;
      end else begin
         n2_v_ff <= n1_v_ff;
      end
   end

   // hidden bit carries into the exponent field; rounding carry may reach infinity
   always_comb begin
      pack = {n2_e_ff - 8'd1, 23'd0} + {7'd0, n2_mant_ff};
      inc  = n2_g_ff & (n2_st_ff | n2_mant_ff[0]);
      rnd  = pack + {30'd0, inc};
   end

   always_ff @(posedge clock) begin
      if (n2_zero_ff) begin
         res_ff <= {n2_s_ff, 31'd0};
      end else if (n2_ovf_ff) begin
         res_ff <= {n2_s_ff, 8'hFF, 23'd0};
      end else begin
         res_ff <= {n2_s_ff, rnd};
      end
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= n2_v_ff;
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

// ===== rtl/core/bpt_dp.sv =====
// datapath: calibration registers, sample latch, register file, float unit, output word
module bpt_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  bpt_pkg::ctl_cmd_type  cmd,
   output bpt_pkg::ctl_sts_type  sts,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [47:0]           csr_wdata,
   input  logic [23:0]           in_raw_pressure,
   input  logic [23:0]           in_raw_temperature,
   input  logic                  out_ready,
   output logic                  out_valid,
   output logic [31:0]           out_temperature_bits,
   output logic [31:0]           out_pressure_bits,
   output logic                  out_reading_toggle
);

   logic [39:0] temp_coeffs_ff;
   logic [47:0] press_a_ff;
   logic [31:0] press_b_ff;
   logic [47:0] press_c_ff;

   logic [23:0] raw_p_ff, raw_t_ff;

   logic [31:0] rf_mem [32];
   logic [31:0] rda_ff, rdb_ff;
   bpt_pkg::instr_type op_ff;
   logic        rd_v_ff;

   logic signed [24:0] sv;
   logic [24:0]        sv_neg;
   logic [23:0]        cmag;
   logic signed [11:0] cscale;

   logic        fpu_done;
   logic [31:0] fpu_res;

   logic [31:0] tl_hold_ff, pr_hold_ff;
   logic        out_v_ff, tog_ff;
   logic [31:0] out_t_ff, out_p_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_coeffs_ff <= '0;
         press_a_ff     <= '0;
         press_b_ff     <= '0;
         press_c_ff     <= '0;
      end else if (csr_we) begin
         case (csr_index)
            bpt_pkg::CSR_TEMP:    temp_coeffs_ff <= csr_wdata[39:0];
            bpt_pkg::CSR_PRESS_A: press_a_ff     <= csr_wdata;
            bpt_pkg::CSR_PRESS_B: press_b_ff     <= csr_wdata[31:0];
            bpt_pkg::CSR_PRESS_C: press_c_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         raw_p_ff <= in_raw_pressure;
         raw_t_ff <= in_raw_temperature;
      end
   end

   // register file: registered two-port read, one write from the float unit
   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         rda_ff <= rf_mem[cmd.instr.srca];
         rdb_ff <= rf_mem[cmd.instr.srcb];
         op_ff  <= cmd.instr;
      end
      if (fpu_done) begin
         rf_mem[op_ff.dst] <= fpu_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff <= 1'b0;
      end else begin
         rd_v_ff <= cmd.issue;
      end
   end

   // integer source of a conversion
   always_comb begin
      case (op_ff.srca)
         bpt_pkg::R_T1:  sv = {9'd0, temp_coeffs_ff[15:0]};
         bpt_pkg::R_T2:  sv = {9'd0, temp_coeffs_ff[31:16]};
         bpt_pkg::R_T3:  sv = {{17{temp_coeffs_ff[39]}}, temp_coeffs_ff[39:32]};
         bpt_pkg::R_P1:  sv = {{9{press_a_ff[15]}}, press_a_ff[15:0]} - 25'sd16384;
         bpt_pkg::R_P2:  sv = {{9{press_a_ff[31]}}, press_a_ff[31:16]} - 25'sd16384;
         bpt_pkg::R_P3:  sv = {{17{press_a_ff[39]}}, press_a_ff[39:32]};
         bpt_pkg::R_P4:  sv = {{17{press_a_ff[47]}}, press_a_ff[47:40]};
         bpt_pkg::R_P5:  sv = {9'd0, press_b_ff[15:0]};
         bpt_pkg::R_P6:  sv = {9'd0, press_b_ff[31:16]};
         bpt_pkg::R_P7:  sv = {{17{press_c_ff[7]}}, press_c_ff[7:0]};
         bpt_pkg::R_P8:  sv = {{17{press_c_ff[15]}}, press_c_ff[15:8]};
         bpt_pkg::R_P9:  sv = {{9{press_c_ff[31]}}, press_c_ff[31:16]};
         bpt_pkg::R_P10: sv = {{17{press_c_ff[39]}}, press_c_ff[39:32]};
         bpt_pkg::R_P11: sv = {{17{press_c_ff[47]}}, press_c_ff[47:40]};
         bpt_pkg::R_UP:  sv = {1'b0, raw_p_ff};
         bpt_pkg::R_UT:  sv = {1'b0, raw_t_ff};
         default:        sv = '0;
      endcase
      sv_neg = 25'd0 - sv;
      cmag   = sv[24] ? sv_neg[23:0] : sv[23:0];
      cscale = bpt_pkg::cvt_scale(op_ff.srca);
   end

   bpt_fpu u_fpu (
      .clock     (clock),
      .reset     (reset),
      .start     (rd_v_ff),
      .op        (op_ff.op),
      .opa       (rda_ff),
      .opb       (rdb_ff),
      .cvt_mag   (cmag),
      .cvt_neg   (sv[24]),
      .cvt_scale (cscale),
      .done      (fpu_done),
      .result    (fpu_res)
   );

   always_ff @(posedge clock) begin
      if (fpu_done && (op_ff.dst == bpt_pkg::R_TL)) tl_hold_ff <= fpu_res;
      if (fpu_done && (op_ff.dst == bpt_pkg::R_F))  pr_hold_ff <= fpu_res;
   end

   // output word holds until taken, the next sample can run meanwhile
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_t_ff <= tl_hold_ff;
         out_p_ff <= pr_hold_ff;
      end
      if (reset) begin
         out_v_ff <= 1'b0;
         tog_ff   <= 1'b0;
      end else begin
         if (cmd.load_out) begin
            out_v_ff <= 1'b1;
            tog_ff   <= ~tog_ff;
         end else if (out_ready) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   assign sts.op_done  = fpu_done;
   assign sts.out_free = ~out_v_ff | out_ready;

   assign out_valid            = out_v_ff;
   assign out_temperature_bits = out_t_ff;
   assign out_pressure_bits    = out_p_ff;
   assign out_reading_toggle   = tog_ff;

endmodule

// ===== rtl/core/bpt_ctrl.sv =====
// controller: steps the microprogram through the float unit one operation at a time
module bpt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  bpt_pkg::ctl_sts_type sts,
   output bpt_pkg::ctl_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_ISSUE  = 4'b0010,
      ST_WAIT   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type  state_ff, state_in;
   logic [5:0] pc_ff, pc_in;

   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      cmd.load_in  = 1'b0;
      cmd.issue    = 1'b0;
      cmd.load_out = 1'b0;
      cmd.instr    = bpt_pkg::prog(pc_ff);
      in_ready     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load_in = 1'b1;
               pc_in       = 6'd0;
               state_in    = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            cmd.issue = 1'b1;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (sts.op_done) begin
               if (pc_ff == bpt_pkg::PcLast) begin
                  state_in = ST_FINISH;
               end else begin
                  pc_in    = pc_ff + 6'd1;
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff    <= 6'd0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
      end
   end

endmodule

// ===== rtl/core/baro_pressure_temp_compensation.sv =====
// Barometric compensation top level.
// req_ch carries one raw 24-bit pressure and one raw 24-bit temperature sample;
// rsp_ch returns the compensated temperature (deg C) and pressure (Pa) as binary32
// bit patterns plus a toggle that flips on every reading.
// Calibration is written through csr_we / csr_index / csr_wdata (index 0
// temperature coefficients, 1..3 pressure coefficient groups) while the block
// is idle: the user must keep to this, the block itself does not enforce it.
// One shared binary32 unit runs a 45-operation microprogram (16 conversions,
// 29 add/sub/multiply); each operation passes register file read, operate,
// leading-one search, shift, round and write back before the next is issued.
// A new sample is taken only after the last result word is loaded for output.
// The result sits in an output register: while it waits to be taken the next
// sample is accepted and computed, and only its final load waits for the slot.
// Synchronous reset clears the calibration registers to zero, the toggle to
// zero and drops any pending word; the register file is not cleared.
module baro_pressure_temp_compensation (
   input  logic        clock,
   input  logic        reset,
   bpt_req_if.sink     req_ch,
   bpt_rsp_if.source   rsp_ch,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [47:0] csr_wdata
);

   bpt_pkg::ctl_cmd_type ctl_cmd;
   bpt_pkg::ctl_sts_type ctl_sts;

   bpt_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_ch.valid),
      .in_ready (req_ch.ready),
      .sts      (ctl_sts),
      .cmd      (ctl_cmd)
   );

   bpt_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (ctl_cmd),
      .sts                  (ctl_sts),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .in_raw_pressure      (req_ch.raw_pressure),
      .in_raw_temperature   (req_ch.raw_temperature),
      .out_ready            (rsp_ch.ready),
      .out_valid            (rsp_ch.valid),
      .out_temperature_bits (rsp_ch.temperature_bits),
      .out_pressure_bits    (rsp_ch.pressure_bits),
      .out_reading_toggle   (rsp_ch.reading_toggle)
   );

`ifndef SYNTH
   // a sample in work blocks the next one
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("sample accepted while busy");

   // one operation in flight in the float unit
   a_single_issue: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.issue |=> !ctl_cmd.issue)
      else $error("back to back issue");

   // a finished word never overwrites one still waiting
   a_load_into_free: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.load_out |-> ctl_sts.out_free)
      else $error("output word overwritten");
`endif

endmodule
